### design/hgwf_pkg.sv
// Package for the heartbeat gated watchdog feeder.
// Holds the field widths, opcodes, fault and stage codes, and the item, result and state structs.
// Has no dependencies.
package hgwf_pkg;

    localparam int unsigned W_TIME     = 32;
    localparam int unsigned W_BEAT     = 32;
    localparam int unsigned W_CNT      = 32;
    localparam int unsigned W_INTERVAL = 16;
    localparam int unsigned W_FAULT    = 2;
    localparam int unsigned W_STAGE    = 2;
    localparam int unsigned W_OP       = 2;

    localparam int unsigned W_S_TDATA  = 136;
    localparam int unsigned W_M_TDATA  = 72;
    localparam int unsigned W_PADDR    = 3;
    localparam int unsigned W_PDATA    = 32;

    localparam logic [W_INTERVAL-1:0] DEFAULT_SERVICE_INTERVAL_MS = 16'd100;
    localparam logic [W_PADDR-1:0]    REG_SERVICE_INTERVAL        = 3'd0;

    typedef enum logic [W_OP-1:0] {
        OP_ARM     = 2'd0,
        OP_SERVICE = 2'd1,
        OP_MAINT   = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    localparam logic [W_FAULT-1:0] FAULT_NONE       = 2'd0;
    localparam logic [W_FAULT-1:0] FAULT_START      = 2'd1;

    localparam logic [W_STAGE-1:0] STAGE_NONE       = 2'd0;
    localparam logic [W_STAGE-1:0] STAGE_START      = 2'd1;
    localparam logic [W_STAGE-1:0] STAGE_FLAGS      = 2'd2;

    typedef struct packed {
        t_op                op;
        logic [W_TIME-1:0]  now_ms;
        logic [W_BEAT-1:0]  adc_beat;
        logic [W_BEAT-1:0]  motor_a_beat;
        logic [W_BEAT-1:0]  motor_b_beat;
        logic [W_FAULT-1:0] arm_fault;
    } t_item;

    typedef struct packed {
        logic               feed;
        logic               release_motors;
        logic               health_ok;
        logic               armed;
        logic               arm_failed;
        logic [W_STAGE-1:0] fail_stage;
        logic [W_CNT-1:0]   feeds_total;
        logic [W_CNT-1:0]   rejects_total;
    } t_result;

    typedef struct packed {
        logic               enabled;
        logic               failed;
        logic [W_STAGE-1:0] stage;
        logic               health;
        logic [W_TIME-1:0]  last_feed;
        logic [W_BEAT-1:0]  adc_snap;
        logic [W_BEAT-1:0]  motor_a_snap;
        logic [W_BEAT-1:0]  motor_b_snap;
        logic [W_CNT-1:0]   feed_cnt;
        logic [W_CNT-1:0]   reject_cnt;
    } t_state;

endpackage

### design/hgwf_update.sv
// Next-state and result logic for one transaction of the watchdog feeder.
// Purely combinational. Depends on hgwf_pkg.
module hgwf_update
    import hgwf_pkg::*;
(
    input  t_state                i_state,
    input  t_item                 i_item,
    input  logic [W_INTERVAL-1:0] i_interval,
    output t_state                o_state,
    output t_result               o_result
);

    logic [W_TIME-1:0] elapsed;
    logic              due;
    logic              healthy;
    logic              feed;
    logic              release_motors;

    assign elapsed = i_item.now_ms - i_state.last_feed;
    assign due     = elapsed >= {{(W_TIME-W_INTERVAL){1'b0}}, i_interval};
    assign healthy = (i_item.adc_beat     != i_state.adc_snap)     &&
                     (i_item.motor_a_beat != i_state.motor_a_snap) &&
                     (i_item.motor_b_beat != i_state.motor_b_snap);

    always_comb begin
        o_state        = i_state;
        feed           = 1'b0;
        release_motors = 1'b0;
        case (i_item.op)
            OP_ARM: begin
                o_state.adc_snap     = i_item.adc_beat;
                o_state.motor_a_snap = i_item.motor_a_beat;
                o_state.motor_b_snap = i_item.motor_b_beat;
                o_state.last_feed    = i_item.now_ms;
                if (i_item.arm_fault == FAULT_NONE) begin
                    o_state.failed  = 1'b0;
                    o_state.stage   = STAGE_NONE;
                    o_state.enabled = 1'b1;
                    o_state.health  = 1'b1;
                end else begin
                    o_state.failed  = 1'b1;
                    o_state.stage   = (i_item.arm_fault == FAULT_START) ? STAGE_START
                                                                        : STAGE_FLAGS;
                    o_state.enabled = 1'b0;
                    o_state.health  = 1'b0;
                    release_motors  = 1'b1;
                end
            end
            OP_SERVICE: begin
                if (i_state.failed) begin
                    release_motors = 1'b1;
                end else if (i_state.enabled && due) begin
                    o_state.health = healthy;
                    if (healthy) begin
                        o_state.adc_snap     = i_item.adc_beat;
                        o_state.motor_a_snap = i_item.motor_a_beat;
                        o_state.motor_b_snap = i_item.motor_b_beat;
                        o_state.last_feed    = i_item.now_ms;
                        o_state.feed_cnt     = i_state.feed_cnt + 1'b1;
                        feed                 = 1'b1;
                    end else begin
                        o_state.reject_cnt   = i_state.reject_cnt + 1'b1;
                    end
                end
            end
            OP_MAINT: begin
                if (i_state.enabled && !i_state.failed) begin
                    o_state.last_feed = i_item.now_ms;
                    o_state.feed_cnt  = i_state.feed_cnt + 1'b1;
                    feed              = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.feed           = feed;
        o_result.release_motors = release_motors;
        o_result.health_ok      = o_state.health;
        o_result.armed          = o_state.enabled;
        o_result.arm_failed     = o_state.failed;
        o_result.fail_stage     = o_state.stage;
        o_result.feeds_total    = o_state.feed_cnt;
        o_result.rejects_total  = o_state.reject_cnt;
    end

endmodule

### design/heartbeat_gated_watchdog_feeder_core.sv
// Top level of the heartbeat gated watchdog feeder: input stage, state, result stage, APB regs.
// Depends on hgwf_pkg and hgwf_update.
//
//   port group      dir   handshake                  contents
//   s_axis_*        in    tvalid/tready              one transaction per supervision event
//   m_axis_*        out   tvalid/tready              one result per input transaction
//   psel/penable    in    pready (always high)       service_interval_ms at byte address 0
//
// Order: input stage holds the accepted transaction; result stage registers its result.
// Throughput: one per cycle while m_axis_tready is high; set by the single state update per cycle.
// Reset: synchronous, active low; clears the state and both valid flags, interval returns to 100 ms.
// Stalls: s_axis_tready drops only while both stages hold a transaction and m_axis_tready is low.
module heartbeat_gated_watchdog_feeder_core
    import hgwf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [31:0] now_ms, [63:32] adc_beat, [95:64] motor_a_beat, [127:96] motor_b_beat,
    // [129:128] arm_fault, [135:130] zero
    input  logic [W_S_TDATA-1:0]  s_axis_tdata,
    // [1:0] op
    input  logic [W_OP-1:0]       s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] feed, [1] release_motors, [2] health_ok, [3] armed, [4] arm_failed,
    // [6:5] fail_stage, [38:7] feeds_total, [70:39] rejects_total, [71] zero
    output logic [W_M_TDATA-1:0]  m_axis_tdata,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [W_PADDR-1:0]    paddr,
    input  logic [W_PDATA-1:0]    pwdata,
    output logic [W_PDATA-1:0]    prdata,
    output logic                  pready
);

    logic [W_INTERVAL-1:0] r_interval;
    logic                  r_in_valid;
    t_item                 r_item;
    t_state                r_state;
    logic                  r_out_valid;
    t_result               r_result;

    t_state                n_state;
    t_result               n_result;
    logic                  advance;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= DEFAULT_SERVICE_INTERVAL_MS;
        end else if (psel && penable && pwrite && pready && paddr == REG_SERVICE_INTERVAL) begin
            r_interval <= pwdata[W_INTERVAL-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_SERVICE_INTERVAL) begin
            prdata = {{(W_PDATA-W_INTERVAL){1'b0}}, r_interval};
        end
    end

    // input stage
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item.op           <= t_op'(s_axis_tuser);
            r_item.now_ms       <= s_axis_tdata[31:0];
            r_item.adc_beat     <= s_axis_tdata[63:32];
            r_item.motor_a_beat <= s_axis_tdata[95:64];
            r_item.motor_b_beat <= s_axis_tdata[127:96];
            r_item.arm_fault    <= s_axis_tdata[129:128];
        end
    end

    hgwf_update u_update (
        .i_state    (r_state),
        .i_item     (r_item),
        .i_interval (r_interval),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0,
                            r_result.rejects_total,
                            r_result.feeds_total,
                            r_result.fail_stage,
                            r_result.arm_failed,
                            r_result.armed,
                            r_result.health_ok,
                            r_result.release_motors,
                            r_result.feed};

endmodule

### design/hgwf_checker.sv
// Port-level checks for heartbeat_gated_watchdog_feeder_core, attached by bind.
// Depends on hgwf_pkg.
module hgwf_checker
    import hgwf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic [W_M_TDATA-1:0] m_axis_tdata,
    input  logic                 pready
);

    // held result must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // feed and motor release never in the same transaction
    a_feed_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("feed with motor release");

    // armed and failed are exclusive; failed implies a stage code
    a_arm_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]) &&
                          (m_axis_tdata[4] == (m_axis_tdata[6:5] != STAGE_NONE)))
        else $error("inconsistent arm status");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind heartbeat_gated_watchdog_feeder_core hgwf_checker u_hgwf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
